// ===== rtl/luma_windowed_chroma_stretch_defines.svh =====
// Assertion macros shared by the chroma stretch RTL.
`ifndef LUMA_WINDOWED_CHROMA_STRETCH_DEFINES_SVH
`define LUMA_WINDOWED_CHROMA_STRETCH_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define LWCS_ASSERT_SAME(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("lwcs: same-cycle check failed");

// next-cycle implication
`define LWCS_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("lwcs: next-cycle check failed");

`else

`define LWCS_ASSERT_SAME(lbl, ck, rs, ante, cons)
`define LWCS_ASSERT_NEXT(lbl, ck, rs, ante, cons)

`endif

`endif

// ===== rtl/lwcs_pkg.sv =====
package lwcs_pkg;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    REG_UPPER = 3'd0,
    REG_LOWER = 3'd1,
    REG_GAIN  = 3'd2,
    REG_SAT   = 3'd3,
    REG_DRIVE = 3'd4
  } reg_idx_t;

  localparam logic [7:0] UPPER_RST = 8'd255;
  localparam logic [7:0] LOWER_RST = 8'd0;
  localparam logic [9:0] GAIN_RST  = 10'd40;
  localparam logic [9:0] SAT_RST   = 10'd0;
  localparam logic [9:0] DRIVE_RST = 10'd0;

  localparam logic [9:0] PCT_MAX = 10'd1000;

  // reciprocal multipliers: floor(x / D) = (x * M) >> K over the ranges used
  localparam logic [10:0] RCP50_M    = 11'd1311;       // K = 16
  localparam logic [15:0] RCP1000S_M = 16'd33555;      // K = 25
  localparam logic [20:0] RCP1000L_M = 21'd1073742;    // K = 30
  localparam logic [24:0] RCP625_M   = 25'd27487791;   // K = 34
  localparam logic [16:0] RCP25_M    = 17'd83887;      // K = 21

  localparam logic [9:0]  ROUND_HALF = 10'd500;
  localparam logic [9:0]  DRV_GAIN_K = 10'd896;
  localparam logic [5:0]  DRV_TWIST_K = 6'd62;
  localparam logic [3:0]  SPREAD_BASE = 4'd12;

  localparam logic [15:0] GAIN_MAX  = 16'd32768;
  localparam logic [7:0]  TWIST_MAX = 8'd192;

  localparam int KNEE = 118;

  // cycles from a register write until the derived values are settled
  localparam logic [2:0] SETTLE_CYCLES = 3'd4;

  typedef struct packed {
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [15:0] gain;
    logic [7:0]  twist;
    logic        guard;
  } derived_t;

  typedef struct packed {
    logic [7:0] luma_in;
    logic [7:0] cb_in;
    logic [7:0] cr_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] luma_out;
    logic [7:0] cb_out;
    logic [7:0] cr_out;
    logic       in_window;
  } pix_out_t;

endpackage

// ===== rtl/lwcs_cfg.sv =====
`include "luma_windowed_chroma_stretch_defines.svh"

module lwcs_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lwcs_pkg::ADDR_W-1:0]  paddr,
  input  logic [lwcs_pkg::DATA_W-1:0]  pwdata,
  output logic [lwcs_pkg::DATA_W-1:0]  prdata,
  output logic                         settled,
  output lwcs_pkg::derived_t           derived
);

  logic [7:0] upper_bound;
  logic [7:0] lower_bound;
  logic [9:0] gain_factor;
  logic [9:0] saturation_amp;
  logic [9:0] drive_level;
  logic       wr;
  lwcs_pkg::reg_idx_t idx;
  logic [2:0] settle_cnt;

  assign wr  = psel && penable && pwrite;
  assign idx = lwcs_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_bound    <= lwcs_pkg::UPPER_RST;
      lower_bound    <= lwcs_pkg::LOWER_RST;
      gain_factor    <= lwcs_pkg::GAIN_RST;
      saturation_amp <= lwcs_pkg::SAT_RST;
      drive_level    <= lwcs_pkg::DRIVE_RST;
    end else if (wr) begin
      unique case (idx)
        lwcs_pkg::REG_UPPER: upper_bound    <= pwdata[7:0];
        lwcs_pkg::REG_LOWER: lower_bound    <= pwdata[7:0];
        lwcs_pkg::REG_GAIN:  gain_factor    <= pwdata[9:0];
        lwcs_pkg::REG_SAT:   saturation_amp <= pwdata[9:0];
        lwcs_pkg::REG_DRIVE: drive_level    <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      lwcs_pkg::REG_UPPER: prdata = {24'd0, upper_bound};
      lwcs_pkg::REG_LOWER: prdata = {24'd0, lower_bound};
      lwcs_pkg::REG_GAIN:  prdata = {22'd0, gain_factor};
      lwcs_pkg::REG_SAT:   prdata = {22'd0, saturation_amp};
      lwcs_pkg::REG_DRIVE: prdata = {22'd0, drive_level};
      default:             prdata = '0;
    endcase
  end

  // any write restarts the settle window; reset starts one too
  always_ff @(posedge clk) begin
    if (rst) begin
      settle_cnt <= lwcs_pkg::SETTLE_CYCLES;
    end else if (wr) begin
      settle_cnt <= lwcs_pkg::SETTLE_CYCLES;
    end else if (settle_cnt != 3'd0) begin
      settle_cnt <= settle_cnt - 3'd1;
    end
  end

  assign settled = (settle_cnt == 3'd0);

  // ---- derivation stage 1: saturate, order bounds, first products
  logic [9:0]  g_sat, s_sat, d_sat;
  logic [20:0] q50_prod;

  assign g_sat    = (gain_factor > lwcs_pkg::PCT_MAX) ? lwcs_pkg::PCT_MAX : gain_factor;
  assign s_sat    = (saturation_amp > lwcs_pkg::PCT_MAX) ? lwcs_pkg::PCT_MAX : saturation_amp;
  assign d_sat    = (drive_level > lwcs_pkg::PCT_MAX) ? lwcs_pkg::PCT_MAX : drive_level;
  assign q50_prod = d_sat * lwcs_pkg::RCP50_M;

  logic [9:0]  g1, d1;
  logic [7:0]  lo1, hi1;
  logic [4:0]  q1;
  logic [19:0] gs1;
  logic [19:0] bonus_num1;
  logic [15:0] twist_num1;
  logic        snz1, dnz1;

  always_ff @(posedge clk) begin
    g1         <= g_sat;
    d1         <= d_sat;
    lo1        <= (lower_bound > upper_bound) ? upper_bound : lower_bound;
    hi1        <= (lower_bound > upper_bound) ? lower_bound : upper_bound;
    q1         <= q50_prod[20:16];
    gs1        <= g_sat * s_sat;
    bonus_num1 <= 20'(d_sat * lwcs_pkg::DRV_GAIN_K) + 20'(lwcs_pkg::ROUND_HALF);
    twist_num1 <= 16'(d_sat * lwcs_pkg::DRV_TWIST_K) + 16'(lwcs_pkg::ROUND_HALF);
    snz1       <= (s_sat != 10'd0);
    dnz1       <= (d_sat != 10'd0);
  end

  // ---- derivation stage 2: constant divisions by reciprocal products
  logic [48:0] fix_s_prod;
  logic [32:0] fix_g_prod;
  logic [40:0] bonus_prod;
  logic [36:0] twist_prod;

  assign fix_s_prod = {gs1, 4'd0} * lwcs_pkg::RCP625_M;      // g*s*16/625
  assign fix_g_prod = {g1, 6'd0} * lwcs_pkg::RCP25_M;        // g*64/25
  assign bonus_prod = bonus_num1 * lwcs_pkg::RCP1000L_M;
  assign twist_prod = twist_num1 * lwcs_pkg::RCP1000L_M;

  logic [14:0] spread_num2;
  logic [14:0] fixed2;
  logic [9:0]  bonus2;
  logic [6:0]  twist2;
  logic [7:0]  lo2, hi2;
  logic        dnz2, guard2;

  always_ff @(posedge clk) begin
    spread_num2 <= 15'(d1 * ({1'b0, q1} + 6'(lwcs_pkg::SPREAD_BASE)))
                   + 15'(lwcs_pkg::ROUND_HALF);
    fixed2      <= snz1 ? fix_s_prod[48:34] : {3'd0, fix_g_prod[32:21]};
    bonus2      <= bonus_prod[39:30];
    twist2      <= twist_prod[36:30];
    lo2         <= lo1;
    hi2         <= hi1;
    dnz2        <= dnz1;
    guard2      <= dnz1 || snz1;
  end

  // ---- derivation stage 3: spread, gain sum, limits
  logic [30:0] spread_prod;
  logic [15:0] gain_sum;

  assign spread_prod = spread_num2 * lwcs_pkg::RCP1000S_M;
  assign gain_sum    = {1'b0, fixed2} + {6'd0, bonus2};

  logic [5:0]  spread3;
  logic [15:0] gain3;
  logic [7:0]  twist3;
  logic [7:0]  lo3, hi3;
  logic        dnz3, guard3;

  always_ff @(posedge clk) begin
    spread3 <= spread_prod[30:25];
    gain3   <= (gain_sum > lwcs_pkg::GAIN_MAX) ? lwcs_pkg::GAIN_MAX : gain_sum;
    twist3  <= ({1'b0, twist2} > lwcs_pkg::TWIST_MAX) ? lwcs_pkg::TWIST_MAX : {1'b0, twist2};
    lo3     <= lo2;
    hi3     <= hi2;
    dnz3    <= dnz2;
    guard3  <= guard2;
  end

  // ---- derivation stage 4: widened window, never empty
  logic [7:0] lo_w, hi_w, lo_f, hi_f;
  logic [8:0] hi_sum;

  always_comb begin
    hi_sum = {1'b0, hi3} + {3'd0, spread3};
    if (dnz3) begin
      lo_w = ({2'd0, spread3} > lo3) ? 8'd0 : lo3 - {2'd0, spread3};
      hi_w = hi_sum[8] ? 8'd255 : hi_sum[7:0];
    end else begin
      lo_w = lo3;
      hi_w = hi3;
    end
    lo_f = lo_w;
    hi_f = hi_w;
    if (lo_w >= hi_w) begin
      if (hi_w != 8'd255) begin
        hi_f = hi_w + 8'd1;
      end else if (lo_w != 8'd0) begin
        lo_f = lo_w - 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    derived.lo    <= lo_f;
    derived.hi    <= hi_f;
    derived.gain  <= gain3;
    derived.twist <= twist3;
    derived.guard <= guard3;
  end

  logic limits_ok;

  assign limits_ok = (derived.gain <= lwcs_pkg::GAIN_MAX)
                     && (derived.twist <= lwcs_pkg::TWIST_MAX);

  `LWCS_ASSERT_NEXT(a_write_unsettles, clk, rst, wr, !settled)
  `LWCS_ASSERT_SAME(a_window_order, clk, rst, settled, derived.lo < derived.hi)
  `LWCS_ASSERT_SAME(a_gain_limits, clk, rst, settled, limits_ok)

endmodule

// ===== rtl/lwcs_pix.sv =====
`include "luma_windowed_chroma_stretch_defines.svh"

module lwcs_pix (
  input  logic                clk,
  input  logic                rst,
  input  logic                settled,
  input  lwcs_pkg::derived_t  derived,
  input  logic                in_valid,
  output logic                in_ready,
  input  lwcs_pkg::pix_in_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lwcs_pkg::pix_out_t  out_data
);

  function automatic logic [7:0] shape(input logic signed [19:0] v, input logic guard);
    logic signed [19:0] c;
    begin
      if (guard) begin
        c = v - 20'sd128;
        if (c > 20'(lwcs_pkg::KNEE)) begin
          c = 20'(lwcs_pkg::KNEE) + ((c - 20'(lwcs_pkg::KNEE)) >>> 2);
        end else if (c < -20'(lwcs_pkg::KNEE)) begin
          c = -20'(lwcs_pkg::KNEE) + ((c + 20'(lwcs_pkg::KNEE)) >>> 2);
        end
        if (c > 20'sd127) begin
          c = 20'sd127;
        end else if (c < -20'sd128) begin
          c = -20'sd128;
        end
        c = c + 20'sd128;
      end else begin
        c = v;
        if (c > 20'sd255) begin
          c = 20'sd255;
        end else if (c < 20'sd0) begin
          c = 20'sd0;
        end
      end
      shape = c[7:0];
    end
  endfunction

  logic v1, v2, v3;
  logic r1, r2, r3;

  assign r3       = !v3 || out_ready;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_ready = r1 && settled;

  // ---- stage 1: window test and the four products
  logic signed [7:0]  cb_c, cr_c;
  logic signed [16:0] gain_s;
  logic signed [8:0]  twist_s;

  assign cb_c    = signed'(in_data.cb_in ^ 8'h80);
  assign cr_c    = signed'(in_data.cr_in ^ 8'h80);
  assign gain_s  = signed'({1'b0, derived.gain});
  assign twist_s = signed'({1'b0, derived.twist});

  logic [7:0]         luma1, cb_raw1, cr_raw1;
  logic               win1;
  logic signed [7:0]  cb1, cr1;
  logic signed [24:0] cbg1, crg1;
  logic signed [16:0] crt1, cbt1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (r1) begin
      v1 <= in_valid && settled;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      luma1   <= in_data.luma_in;
      cb_raw1 <= in_data.cb_in;
      cr_raw1 <= in_data.cr_in;
      win1    <= (in_data.luma_in > derived.lo) && (in_data.luma_in < derived.hi);
      cb1     <= cb_c;
      cr1     <= cr_c;
      cbg1    <= cb_c * gain_s;
      crg1    <= cr_c * gain_s;
      crt1    <= cr_c * twist_s;
      cbt1    <= cb_c * twist_s;
    end
  end

  // ---- stage 2: stretched and cross-mixed chroma
  logic signed [19:0] ocb, ocr;

  assign ocb = 20'sd128 + 20'(cb1) + 20'(cbg1 >>> 8) + 20'(crt1 >>> 8);
  assign ocr = 20'sd128 + 20'(cr1) - 20'(crg1 >>> 8) - 20'(cbt1 >>> 8);

  logic [7:0]         luma2, cb_raw2, cr_raw2;
  logic               win2;
  logic signed [19:0] ocb2, ocr2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (r2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (r2) begin
      luma2   <= luma1;
      cb_raw2 <= cb_raw1;
      cr_raw2 <= cr_raw1;
      win2    <= win1;
      ocb2    <= ocb;
      ocr2    <= ocr;
    end
  end

  // ---- stage 3: knee or clamp, output register
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (r3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (r3) begin
      out_data.luma_out  <= luma2;
      out_data.cb_out    <= win2 ? shape(ocb2, derived.guard) : cb_raw2;
      out_data.cr_out    <= win2 ? shape(ocr2, derived.guard) : cr_raw2;
      out_data.in_window <= win2;
    end
  end

  assign out_valid = v3;

  `LWCS_ASSERT_NEXT(a_accept_loads, clk, rst, in_valid && in_ready, v1)
  `LWCS_ASSERT_NEXT(a_mid_stall_holds, clk, rst, v2 && !r2, v2 && $stable(ocb2) && $stable(ocr2))

endmodule

// ===== rtl/luma_windowed_chroma_stretch.sv =====
// Channel  | handshake             | payload
// ---------+-----------------------+---------------------------------------
// config   | psel/penable/pwrite   | paddr, pwdata, prdata (pready tied 1)
// pixel in | in_valid / in_ready   | in_data  (luma_in, cb_in, cr_in)
// pixel out| out_valid / out_ready | out_data (luma_out, cb_out, cr_out, in_window)
//
// One pixel per clock sustained while settled and out_ready is high, through the
// product, sum and knee/clamp stages, each with its own valid bit so bubbles
// collapse on a stall. Derived window/gain/twist come from a 4-stage register
// pipeline; after reset or any register write in_ready stays low while it settles.
// Reset (rst, synchronous) restores the register defaults and empties the pipe.

module luma_windowed_chroma_stretch (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lwcs_pkg::ADDR_W-1:0]  paddr,
  input  logic [lwcs_pkg::DATA_W-1:0]  pwdata,
  output logic [lwcs_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  lwcs_pkg::pix_in_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output lwcs_pkg::pix_out_t           out_data
);

  logic               settled;
  lwcs_pkg::derived_t derived;

  assign pready = 1'b1;

  lwcs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .settled (settled),
    .derived (derived)
  );

  lwcs_pix u_pix (
    .clk       (clk),
    .rst       (rst),
    .settled   (settled),
    .derived   (derived),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
